// ===== rtl/core/bai_pkg.sv =====
package bai_pkg;

   // Built depth of the list and the widths that follow from it.
   localparam int MAX_ENTRIES = 16;
   localparam int IDX_W       = $clog2(MAX_ENTRIES);
   localparam int CNT_W       = 5;
   localparam int POS_W       = 5;
   localparam int OP_W        = 3;
   localparam int WORD_W      = 32;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 3;

   localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(MAX_ENTRIES);
   localparam logic [CNT_W-1:0] CAP_MAX   = CNT_W'(MAX_ENTRIES);
   localparam logic [CNT_W-1:0] CAP_MIN   = CNT_W'(1);

   // Register index, taken from the word address bit of the config port.
   localparam logic [0:0] REG_CAPACITY = 1'b0;

   typedef logic signed [WORD_W-1:0] entry_type;
   typedef entry_type entries_type [MAX_ENTRIES];

   typedef enum logic [OP_W-1:0] {
      OP_APPEND    = 3'd0,
      OP_INSERT    = 3'd1,
      OP_READ      = 3'd2,
      OP_DELETE    = 3'd3,
      OP_OVERWRITE = 3'd4,
      OP_CLEAR     = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE     = 2'd0,
      ST_FULL     = 2'd1,
      ST_BAD_POS  = 2'd2
   } status_type;

   // What a cell loads at the next edge.
   typedef enum logic [1:0] {
      CELL_HOLD       = 2'd0,
      CELL_LOAD       = 2'd1,
      CELL_TAKE_LOWER = 2'd2,
      CELL_TAKE_UPPER = 2'd3
   } cell_ctl_type;

   typedef cell_ctl_type cell_ctls_type [MAX_ENTRIES];

   typedef struct packed {
      status_type         status;
      entry_type          read_data;
      logic [CNT_W-1:0]   element_count;
      logic               is_empty;
      logic               is_full;
   } result_type;

endpackage

// ===== rtl/core/bai_cell.sv =====
module bai_cell (
   input  logic                  clock,
   input  bai_pkg::cell_ctl_type ctl,
   input  bai_pkg::entry_type    data_in,
   input  bai_pkg::entry_type    lower_q,
   input  bai_pkg::entry_type    upper_q,
   output bai_pkg::entry_type    q
);

   bai_pkg::entry_type data_ff;
   bai_pkg::entry_type data_in_sel;

   always_comb begin
      unique case (ctl)
         bai_pkg::CELL_HOLD:       data_in_sel = data_ff;
         bai_pkg::CELL_LOAD:       data_in_sel = data_in;
         bai_pkg::CELL_TAKE_LOWER: data_in_sel = lower_q;
         bai_pkg::CELL_TAKE_UPPER: data_in_sel = upper_q;
         default:                  data_in_sel = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in_sel;
   end

   assign q = data_ff;

endmodule

// ===== rtl/core/bai_ctrl.sv =====
module bai_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_accept,
   input  logic [bai_pkg::OP_W-1:0]     opcode,
   input  logic [bai_pkg::POS_W-1:0]    position,
   input  logic [bai_pkg::CNT_W-1:0]    capacity_raw,
   input  bai_pkg::entries_type         entries,
   output bai_pkg::cell_ctls_type       cell_ctl,
   output bai_pkg::result_type          result
);

   logic [bai_pkg::CNT_W-1:0] fill_count_ff;
   logic [bai_pkg::CNT_W-1:0] fill_count_in;
   logic [bai_pkg::CNT_W-1:0] next_count;
   logic [bai_pkg::CNT_W-1:0] cap;
   logic                      list_full;
   bai_pkg::status_type       status;
   bai_pkg::entry_type        read_data;
   bai_pkg::cell_ctls_type    ctl_raw;
   bai_pkg::op_type           op;

   assign op = bai_pkg::op_type'(opcode);

   // The register value is clamped into 1..depth before it is used.
   always_comb begin
      priority if (capacity_raw < bai_pkg::CAP_MIN) begin
         cap = bai_pkg::CAP_MIN;
      end else if (capacity_raw > bai_pkg::CAP_MAX) begin
         cap = bai_pkg::CAP_MAX;
      end else begin
         cap = capacity_raw;
      end
   end

   assign list_full = (fill_count_ff >= cap);

   always_comb begin
      status     = bai_pkg::ST_DONE;
      read_data  = '0;
      next_count = fill_count_ff;
      for (int i = 0; i < bai_pkg::MAX_ENTRIES; i++) begin
         ctl_raw[i] = bai_pkg::CELL_HOLD;
      end
      unique case (op)
         bai_pkg::OP_APPEND: begin
            if (list_full) begin
               status = bai_pkg::ST_FULL;
            end else begin
               for (int i = 0; i < bai_pkg::MAX_ENTRIES; i++) begin
                  if (bai_pkg::CNT_W'(i) == fill_count_ff) ctl_raw[i] = bai_pkg::CELL_LOAD;
               end
               next_count = fill_count_ff + bai_pkg::CNT_W'(1);
            end
         end
         bai_pkg::OP_INSERT: begin
            priority if (list_full) begin
               status = bai_pkg::ST_FULL;
            end else if (position >= cap) begin
               status = bai_pkg::ST_BAD_POS;
            end else if (position >= fill_count_ff) begin
               // Past the end but inside capacity: same as an append.
               for (int i = 0; i < bai_pkg::MAX_ENTRIES; i++) begin
                  if (bai_pkg::CNT_W'(i) == fill_count_ff) ctl_raw[i] = bai_pkg::CELL_LOAD;
               end
               next_count = fill_count_ff + bai_pkg::CNT_W'(1);
            end else begin
               // Every cell above the position takes its lower neighbor.
               for (int i = 0; i < bai_pkg::MAX_ENTRIES; i++) begin
                  if (bai_pkg::POS_W'(i) > position) begin
                     ctl_raw[i] = bai_pkg::CELL_TAKE_LOWER;
                  end else if (bai_pkg::POS_W'(i) == position) begin
                     ctl_raw[i] = bai_pkg::CELL_LOAD;
                  end
               end
               next_count = fill_count_ff + bai_pkg::CNT_W'(1);
            end
         end
         bai_pkg::OP_READ: begin
            if (position >= fill_count_ff) begin
               status = bai_pkg::ST_BAD_POS;
            end else begin
               read_data = entries[position[bai_pkg::IDX_W-1:0]];
            end
         end
         bai_pkg::OP_DELETE: begin
            if (position >= fill_count_ff) begin
               status = bai_pkg::ST_BAD_POS;
            end else begin
               // The top cell keeps its word; it lies past the new end.
               for (int i = 0; i < bai_pkg::MAX_ENTRIES - 1; i++) begin
                  if (bai_pkg::POS_W'(i) >= position) ctl_raw[i] = bai_pkg::CELL_TAKE_UPPER;
               end
               next_count = fill_count_ff - bai_pkg::CNT_W'(1);
            end
         end
         bai_pkg::OP_OVERWRITE: begin
            if (position >= fill_count_ff) begin
               status = bai_pkg::ST_BAD_POS;
            end else begin
               for (int i = 0; i < bai_pkg::MAX_ENTRIES; i++) begin
                  if (bai_pkg::POS_W'(i) == position) ctl_raw[i] = bai_pkg::CELL_LOAD;
               end
            end
         end
         bai_pkg::OP_CLEAR: begin
            next_count = '0;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      for (int i = 0; i < bai_pkg::MAX_ENTRIES; i++) begin
         cell_ctl[i] = req_accept ? ctl_raw[i] : bai_pkg::CELL_HOLD;
      end
   end

   assign fill_count_in = req_accept ? next_count : fill_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_count_ff <= '0;
      end else begin
         fill_count_ff <= fill_count_in;
      end
   end

   always_comb begin
      result.status        = status;
      result.read_data     = read_data;
      result.element_count = next_count;
      result.is_empty      = (next_count == '0);
      result.is_full       = (next_count >= cap);
   end

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_count_ff <= bai_pkg::CNT_W'(bai_pkg::MAX_ENTRIES))
      else $error("entry count beyond the built depth");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      req_accept && op == bai_pkg::OP_CLEAR |=> fill_count_ff == '0)
      else $error("clear did not empty the list");

   a_error_keeps_count: assert property (@(posedge clock) disable iff (reset)
      req_accept && status != bai_pkg::ST_DONE |=> $stable(fill_count_ff))
      else $error("failed request changed the entry count");

   a_delete_drops_one: assert property (@(posedge clock) disable iff (reset)
      req_accept && op == bai_pkg::OP_DELETE && status == bai_pkg::ST_DONE
      |=> fill_count_ff == $past(fill_count_ff) - bai_pkg::CNT_W'(1))
      else $error("delete did not drop the count by one");

   a_error_holds_cells: assert property (@(posedge clock) disable iff (reset)
      status != bai_pkg::ST_DONE |-> cell_ctl[0] == bai_pkg::CELL_HOLD)
      else $error("failed request moved the bottom cell");

endmodule

// ===== rtl/core/bounded_array_insert_delete.sv =====
// Channel   Direction  Handshake              Payload
// req_      in         req_tvalid/req_tready  tuser opcode; tdata position, data_in
// rsp_      out        rsp_tvalid/rsp_tready  tdata status, read_data, count, flags
// csr_      in         APB, pready always 1   capacity_in_use at byte address 0
//
// Each word is handled in the cycle it is accepted: the row of cells shifts,
// loads or holds at that edge, so insert and delete finish at that edge whatever
// the position. The result is captured in an output register at the same edge.
// One word per cycle is sustained; req_tready drops only while a result waits
// in the output register and rsp_tready is low.
// Reset clears the entry count, the output valid flag and sets the capacity
// to the built depth; the cell contents stay undefined until written.
module bounded_array_insert_delete (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [4:0] position, [36:5] data_in, [39:37] zero
   input  logic [39:0]                       req_tdata,
   // [2:0] opcode
   input  logic [2:0]                        req_tuser,

   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [1:0] status, [33:2] read_data, [38:34] element_count, [39] is_empty,
   // [40] is_full, [47:41] zero
   output logic [47:0]                       rsp_tdata,

   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [bai_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [bai_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [bai_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   // Configuration register. Only the word address bit selects the register.
   logic [bai_pkg::CNT_W-1:0] capacity_ff;
   logic [bai_pkg::CNT_W-1:0] capacity_in;
   logic                      csr_write;
   logic                      csr_hit;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[bai_pkg::CSR_ADDR_W-1:2] == bai_pkg::REG_CAPACITY);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign capacity_in = (csr_write && csr_hit) ? csr_pwdata[bai_pkg::CNT_W-1:0]
                                               : capacity_ff;
   assign csr_prdata = csr_hit ? bai_pkg::CSR_DATA_W'(capacity_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= bai_pkg::CAP_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   // Output register state, used by the input handshake below.
   logic                rsp_tvalid_ff;
   logic                rsp_tvalid_in;
   bai_pkg::result_type rsp_result_ff;
   bai_pkg::result_type rsp_result_in;

   // Input word fields.
   logic                          req_accept;
   logic [bai_pkg::OP_W-1:0]      opcode;
   logic [bai_pkg::POS_W-1:0]     position;
   bai_pkg::entry_type            data_in;

   assign opcode     = req_tuser[bai_pkg::OP_W-1:0];
   assign position   = req_tdata[bai_pkg::POS_W-1:0];
   assign data_in    = req_tdata[bai_pkg::POS_W +: bai_pkg::WORD_W];
   assign req_tready = !rsp_tvalid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   // The row of cells. Each cell sees its two neighbors; the ends see themselves.
   bai_pkg::entries_type   entries;
   bai_pkg::cell_ctls_type cell_ctl;
   bai_pkg::result_type    result;

   for (genvar g = 0; g < bai_pkg::MAX_ENTRIES; g++) begin : g_cell
      bai_pkg::entry_type lower_q;
      bai_pkg::entry_type upper_q;
      if (g == 0) begin : g_bottom
         assign lower_q = entries[g];
      end else begin : g_lower
         assign lower_q = entries[g-1];
      end
      if (g == bai_pkg::MAX_ENTRIES - 1) begin : g_top
         assign upper_q = entries[g];
      end else begin : g_upper
         assign upper_q = entries[g+1];
      end
      bai_cell u_cell (
         .clock   (clock),
         .ctl     (cell_ctl[g]),
         .data_in (data_in),
         .lower_q (lower_q),
         .upper_q (upper_q),
         .q       (entries[g])
      );
   end

   // Decode, entry count and result for the word at the input.
   bai_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_accept   (req_accept),
      .opcode       (opcode),
      .position     (position),
      .capacity_raw (capacity_ff),
      .entries      (entries),
      .cell_ctl     (cell_ctl),
      .result       (result)
   );

   // Output register. It refills in the same cycle it is emptied.
   assign rsp_tvalid_in = req_accept ? 1'b1 : (rsp_tvalid_ff && !rsp_tready);
   assign rsp_result_in = req_accept ? result : rsp_result_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_result_ff <= rsp_result_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {7'b0,
                        rsp_result_ff.is_full,
                        rsp_result_ff.is_empty,
                        rsp_result_ff.element_count,
                        rsp_result_ff.read_data,
                        rsp_result_ff.status};

endmodule

// ===== verif/testbench.sv =====
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   // The two opcodes the block leaves unused. It must answer them with a plain
   // done status and leave the list alone.
   localparam logic [bai_pkg::OP_W-1:0] OP_SPARE_6 = 3'd6;
   localparam logic [bai_pkg::OP_W-1:0] OP_SPARE_7 = 3'd7;

   // Capacity settings for the random phases, phase 0 in the lowest slot. The
   // plan covers zero and 31 (both clamped by the block), one, and the built
   // depth. It also drops the capacity below a fill that an earlier phase left.
   localparam int RANDOM_PHASES    = 13;
   localparam int WORDS_PER_PHASE  = 150;
   localparam logic [RANDOM_PHASES-1:0][4:0] CAPACITY_PLAN = {
      5'd5, 5'd16, 5'd13, 5'd4, 5'd16, 5'd1, 5'd16, 5'd9, 5'd0, 5'd16, 5'd2, 5'd16, 5'd31
   };

   // About 2000 words. Each word can sit out a sender gap and a receiver stall
   // of a few cycles.
   localparam int CYCLE_LIMIT = 400000;

   // One request word as the testbench holds it before it goes onto the bus.
   typedef struct packed {
      logic [bai_pkg::OP_W-1:0]   opcode;
      logic [bai_pkg::POS_W-1:0]  position;
      logic [bai_pkg::WORD_W-1:0] data_word;
   } list_request_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_RANDOM,
      STALL_RUNS,
      STALL_ALTERNATE
   } stall_mode_type;

   // Every input of the block starts at a known value. Reset is high from time zero.
   logic        clock        = 1'b0;
   logic        reset        = 1'b1;
   logic        req_tvalid   = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata    = '0;    // [4:0] position, [36:5] data_in, [39:37] zero
   logic [2:0]  req_tuser    = '0;    // [2:0] opcode
   logic        rsp_tvalid;
   logic        rsp_tready   = 1'b0;
   logic [47:0] rsp_tdata;            // [1:0] status, [33:2] read_data,
                                      // [38:34] element_count, [39] is_empty,
                                      // [40] is_full, [47:41] zero
   logic                           csr_psel    = 1'b0;
   logic                           csr_penable = 1'b0;
   logic                           csr_pwrite  = 1'b0;
   logic [bai_pkg::CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [bai_pkg::CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [bai_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   bounded_array_insert_delete u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // The testbench keeps its own copy of the list: the words, how many of them
   // are live, and the capacity register as last written.
   bai_pkg::entries_type list_words;
   int                   list_len         = 0;
   logic [4:0]           capacity_shadow  = bai_pkg::CAP_RESET;

   list_request_type     request_backlog[$];
   bai_pkg::result_type  predicted_answers[$];

   int words_queued      = 0;
   int words_accepted    = 0;
   int results_checked   = 0;
   int mismatches        = 0;
   int full_answers      = 0;
   int bad_pos_answers   = 0;
   int deepest_fill      = 0;
   int capacity_writes   = 0;
   int cycle_count       = 0;

   // Apply one request word to the list copy and return the result that the
   // block should produce for it. The capacity register holds five bits, so
   // values of zero or above the built depth are clamped first. Full is tested
   // before the position, so an insert into a full list reports full even at a
   // bad position.
   function automatic bai_pkg::result_type apply_list_request(input list_request_type rq);
      bai_pkg::result_type answer;
      int         cap;
      int         pos;
      int         i;
      cap = int'(capacity_shadow);
      if (cap < 1)
         cap = 1;
      if (cap > bai_pkg::MAX_ENTRIES)
         cap = bai_pkg::MAX_ENTRIES;
      pos = int'(rq.position);
      answer.status    = bai_pkg::ST_DONE;
      answer.read_data = '0;
      case (rq.opcode)
         bai_pkg::OP_APPEND: begin
            if (list_len >= cap) begin
               answer.status = bai_pkg::ST_FULL;
            end else begin
               list_words[list_len] = rq.data_word;
               list_len++;
            end
         end
         bai_pkg::OP_INSERT: begin
            if (list_len >= cap) begin
               answer.status = bai_pkg::ST_FULL;
            end else if (pos >= cap) begin
               answer.status = bai_pkg::ST_BAD_POS;
            end else if (pos >= list_len) begin
               // A position past the end but inside the capacity appends.
               list_words[list_len] = rq.data_word;
               list_len++;
            end else begin
               for (i = list_len; i > pos; i--)
                  list_words[i] = list_words[i-1];
               list_words[pos] = rq.data_word;
               list_len++;
            end
         end
         bai_pkg::OP_READ: begin
            if (pos >= list_len)
               answer.status = bai_pkg::ST_BAD_POS;
            else
               answer.read_data = list_words[pos];
         end
         bai_pkg::OP_DELETE: begin
            if (pos >= list_len) begin
               answer.status = bai_pkg::ST_BAD_POS;
            end else begin
               for (i = pos; i + 1 < list_len; i++)
                  list_words[i] = list_words[i+1];
               list_len--;
            end
         end
         bai_pkg::OP_OVERWRITE: begin
            if (pos >= list_len)
               answer.status = bai_pkg::ST_BAD_POS;
            else
               list_words[pos] = rq.data_word;
         end
         bai_pkg::OP_CLEAR: begin
            list_len = 0;
         end
         default: begin
         end
      endcase
      answer.element_count = bai_pkg::CNT_W'(list_len);
      answer.is_empty      = (list_len == 0);
      answer.is_full       = (list_len >= cap);
      if (answer.status == bai_pkg::ST_FULL)
         full_answers++;
      if (answer.status == bai_pkg::ST_BAD_POS)
         bad_pos_answers++;
      if (list_len > deepest_fill)
         deepest_fill = list_len;
      return answer;
   endfunction

   // Sender. Words leave the backlog in bursts of random length, with random
   // gaps between them. Now and then a long burst goes out with no gap at all.
   // The prediction is made at the edge where the word is taken. In that way
   // the list copy moves in step with the block.
   list_request_type on_bus;
   logic             req_taken;
   int               burst_left = 0;
   int               gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         req_taken = req_tvalid && req_tready;
         if (req_taken) begin
            predicted_answers.push_back(apply_list_request(on_bus));
            words_accepted++;
         end
         if (!req_tvalid || req_taken) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (request_backlog.size() != 0) begin
               on_bus = request_backlog.pop_front();
               req_tuser  <= on_bus.opcode;
               req_tdata  <= {3'b000, on_bus.data_word, on_bus.position};
               req_tvalid <= 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = ($urandom_range(0, 9) == 0) ? 80 : $urandom_range(0, 23);
                  gap_left   = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver and checker. Backpressure switches between several patterns: no
   // stall, random stalls, runs of ready and stalled cycles, and every other
   // cycle. Every result taken is compared field by field with the oldest
   // prediction.
   bai_pkg::result_type seen_answer;
   bai_pkg::result_type wanted_answer;
   stall_mode_type      stall_mode  = STALL_NONE;
   int                  mode_left   = 0;
   int                  run_left    = 0;
   logic                ready_phase = 1'b1;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen_answer.status        = bai_pkg::status_type'(rsp_tdata[1:0]);
            seen_answer.read_data     = rsp_tdata[33:2];
            seen_answer.element_count = rsp_tdata[38:34];
            seen_answer.is_empty      = rsp_tdata[39];
            seen_answer.is_full       = rsp_tdata[40];
            if (predicted_answers.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: result word with nothing predicted: status %0d data %0d count %0d",
                           $realtime, seen_answer.status, seen_answer.read_data,
                           seen_answer.element_count);
            end else begin
               wanted_answer = predicted_answers.pop_front();
               results_checked++;
               if (seen_answer.status        !== wanted_answer.status    ||
                   seen_answer.read_data     !== wanted_answer.read_data ||
                   seen_answer.element_count !== wanted_answer.element_count ||
                   seen_answer.is_empty      !== wanted_answer.is_empty  ||
                   seen_answer.is_full       !== wanted_answer.is_full) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("%0t: result %0d mismatch", $realtime, results_checked);
                     $display("   expected status %0d data %0d count %0d empty %0b full %0b",
                              wanted_answer.status, wanted_answer.read_data,
                              wanted_answer.element_count, wanted_answer.is_empty,
                              wanted_answer.is_full);
                     $display("   actual   status %0d data %0d count %0d empty %0b full %0b",
                              seen_answer.status, seen_answer.read_data,
                              seen_answer.element_count, seen_answer.is_empty,
                              seen_answer.is_full);
                  end
               end
            end
         end

         if (mode_left == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 3));
            mode_left  = $urandom_range(40, 300);
         end else begin
            mode_left--;
         end
         case (stall_mode)
            STALL_NONE:      rsp_tready <= 1'b1;
            STALL_RANDOM:    rsp_tready <= ($urandom_range(0, 9) < 6);
            STALL_RUNS: begin
               if (run_left == 0) begin
                  ready_phase = !ready_phase;
                  run_left    = $urandom_range(1, 8);
               end else begin
                  run_left--;
               end
               rsp_tready <= ready_phase;
            end
            default:         rsp_tready <= cycle_count[0];
         endcase
      end
   end

   // A hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end
   end

   task automatic queue_request(input logic [bai_pkg::OP_W-1:0] opcode, input int position,
                                input logic [bai_pkg::WORD_W-1:0] data_word);
      request_backlog.push_back('{opcode, bai_pkg::POS_W'(position), data_word});
      words_queued++;
   endtask

   // Write the capacity register with a setup phase and then an access phase. The
   // register takes the value at the access edge, so the list copy follows it
   // there.
   task automatic write_capacity(input logic [4:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= bai_pkg::CSR_ADDR_W'({bai_pkg::REG_CAPACITY, 2'b00});
      csr_pwdata  <= bai_pkg::CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      capacity_shadow = value;
      capacity_writes++;
   endtask

   // Hold off until every queued word has been taken and every result has
   // come back. Then give the block a few quiet cycles. Every word yields
   // exactly one result, so nothing can still be in flight at that point.
   task automatic settle_list();
      while (words_accepted != words_queued || predicted_answers.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      int phase;
      int n;
      int grow_pct;
      int pick;
      int position;
      logic [bai_pkg::OP_W-1:0]   opcode;
      logic [bai_pkg::WORD_W-1:0] data_word;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed checks at the full built depth. First come a read and a delete at
      // a bad position on an empty list. Then an insert past the end that turns into
      // an append, a shift insert at the head, inserts at bad positions, and deletes
      // at the head and at the tail. Both unused opcodes and a clear follow.
      write_capacity(5'd16);
      queue_request(bai_pkg::OP_READ,      0, 32'd0);
      queue_request(bai_pkg::OP_DELETE,    0, 32'd0);
      queue_request(bai_pkg::OP_INSERT,    5, 32'h7fff_ffff);
      queue_request(bai_pkg::OP_APPEND,    0, 32'h8000_0000);
      queue_request(bai_pkg::OP_INSERT,    0, 32'hffff_ffff);
      queue_request(bai_pkg::OP_INSERT,   16, 32'd5);
      queue_request(bai_pkg::OP_INSERT,   31, 32'd6);
      queue_request(bai_pkg::OP_READ,      0, 32'd0);
      queue_request(bai_pkg::OP_READ,      1, 32'd0);
      queue_request(bai_pkg::OP_OVERWRITE, 1, 32'd0);
      queue_request(bai_pkg::OP_DELETE,    0, 32'd0);
      queue_request(bai_pkg::OP_READ,      0, 32'd0);
      queue_request(bai_pkg::OP_DELETE,    1, 32'd0);
      queue_request(bai_pkg::OP_READ,      5, 32'd0);
      queue_request(OP_SPARE_6,            3, 32'd1);
      queue_request(OP_SPARE_7,           31, 32'hffff_ffff);
      queue_request(bai_pkg::OP_CLEAR,     0, 32'd0);
      queue_request(bai_pkg::OP_APPEND,    0, 32'h1234_5678);
      queue_request(bai_pkg::OP_APPEND,    0, 32'd5);
      settle_list();

      // The capacity drops below the two held entries. Append and insert now
      // report full, but the held entries can still be read, overwritten and
      // deleted.
      write_capacity(5'd1);
      queue_request(bai_pkg::OP_APPEND,    0, 32'd9);
      queue_request(bai_pkg::OP_INSERT,    0, 32'd9);
      queue_request(bai_pkg::OP_READ,      1, 32'd0);
      queue_request(bai_pkg::OP_OVERWRITE, 1, 32'hffff_fff9);
      queue_request(bai_pkg::OP_DELETE,    1, 32'd0);
      settle_list();

      // A capacity of zero behaves as one.
      write_capacity(5'd0);
      queue_request(bai_pkg::OP_APPEND,    0, 32'd3);
      queue_request(bai_pkg::OP_DELETE,    0, 32'd0);
      queue_request(bai_pkg::OP_APPEND,    0, 32'ha5a5_a5a5);
      settle_list();

      // Random phases. Each phase leans toward growing or toward shrinking the
      // list, so that the fill count moves over its whole range. Most positions
      // fall near the live range; the rest cover every position bit. The list
      // carries over between phases. When the next capacity is below the fill, the
      // list is left over capacity.
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         write_capacity(CAPACITY_PLAN[phase]);
         grow_pct = $urandom_range(35, 70);
         for (n = 0; n < WORDS_PER_PHASE; n++) begin
            if ($urandom_range(0, 99) < grow_pct) begin
               opcode = ($urandom_range(0, 1) == 0) ? bai_pkg::OP_APPEND : bai_pkg::OP_INSERT;
            end else begin
               pick = $urandom_range(0, 99);
               if (pick < 36)
                  opcode = bai_pkg::OP_READ;
               else if (pick < 70)
                  opcode = bai_pkg::OP_DELETE;
               else if (pick < 94)
                  opcode = bai_pkg::OP_OVERWRITE;
               else if (pick < 97)
                  opcode = bai_pkg::OP_CLEAR;
               else
                  opcode = ($urandom_range(0, 1) == 0) ? OP_SPARE_6 : OP_SPARE_7;
            end
            position = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 16)
                                                    : $urandom_range(0, 31);
            case ($urandom_range(0, 9))
               0:       data_word = 32'h8000_0000;
               1:       data_word = 32'h7fff_ffff;
               2:       data_word = 32'h0000_0000;
               3:       data_word = 32'hffff_ffff;
               default: data_word = $urandom;
            endcase
            queue_request(opcode, position, data_word);
         end
         settle_list();
      end

      repeat (10) @(posedge clock);
      $display("Sent %0d request words under %0d capacity settings; peak fill was %0d entries.",
               words_accepted, capacity_writes, deepest_fill);
      $display("Checked %0d results, with %0d list-full and %0d bad-position answers.",
               results_checked, full_answers, bad_pos_answers);
      if (mismatches == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule
